// File: hdl/mdio_pkg.sv
// ----------------------------------------------------------------------------
// MDIO management master package
// Shared types, command codes and frame helpers for the MDIO master.
// ----------------------------------------------------------------------------
package mdio_pkg;

	localparam int PREAMBLE_BITS = 32;
	localparam int FRAME_BITS    = 32;
	localparam int CNT_W         = 6;
	localparam int HALF_W        = 16;
	localparam int CFG_AW        = 3;

	typedef enum logic [CFG_AW-3:0] {
		REG_HALF_PERIOD = 1'b0
	} reg_idx_t;

	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_C22_READ  = 3'd1,
		CMD_C22_WRITE = 3'd2,
		CMD_C45_READ  = 3'd3,
		CMD_C45_WRITE = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PRE   = 2'd1,
		PH_FRAME = 2'd2,
		PH_TRAIL = 2'd3
	} phase_t;

	// Start and opcode nibbles of the five frame kinds.
	localparam logic [3:0] STOP_C22_READ  = 4'h6;
	localparam logic [3:0] STOP_C22_WRITE = 4'h5;
	localparam logic [3:0] STOP_C45_ADDR  = 4'h0;
	localparam logic [3:0] STOP_C45_READ  = 4'h3;
	localparam logic [3:0] STOP_C45_WRITE = 4'h1;
	localparam logic [1:0] TA_WRITE       = 2'b10;

	// Bit of a frame that marks a read opcode.
	localparam int READ_BIT = 29;

	typedef struct packed {
		logic [2:0]  command;
		logic [4:0]  port_address;
		logic [4:0]  dev_or_reg;
		logic [15:0] reg_address;
		logic [15:0] write_value;
		logic        mdio_in;
	} req_t;

	typedef struct packed {
		logic        mdc;
		logic        mdio_out;
		logic        mdio_drive;
		logic        busy_res;
		logic [15:0] read_data;
		logic        read_valid;
	} res_t;

	function automatic logic [FRAME_BITS-1:0] make_frame(
		input logic [3:0]  st_op,
		input logic [4:0]  pa,
		input logic [4:0]  ra,
		input logic [15:0] data
	);
		return {st_op, pa, ra, TA_WRITE, data};
	endfunction

endpackage

// File: hdl/mdio_req_if.sv
// ----------------------------------------------------------------------------
// MDIO request channel
// Valid/ready channel carrying one request or tick word.
// ----------------------------------------------------------------------------
interface mdio_req_if;
	import mdio_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/mdio_res_if.sv
// ----------------------------------------------------------------------------
// MDIO result channel
// Valid/ready channel carrying one line-state word per request word.
// ----------------------------------------------------------------------------
interface mdio_res_if;
	import mdio_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/mdio_management_master_unit.sv
// ----------------------------------------------------------------------------
// MDIO management master
// Clause 22 / clause 45 MDIO frame generator stepped by tick words.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Word
// req       in   valid/ready        command, addresses, write value, mdio_in
// res       out  valid/ready        mdc, mdio_out, mdio_drive, busy, read data
// apb       in   psel/penable       half_period_ticks at byte address 0
//
// Each request word is applied and its result word is registered at the same
// edge; a new word is taken every cycle while the result is taken.
// The output register is the only buffer: req.ready drops only while a result
// waits and res.ready is low.
// Reset puts MDC high, MDIO released and the block idle; read data clears.
// ----------------------------------------------------------------------------
module mdio_management_master_unit
	import mdio_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	mdio_req_if.sink            req,
	mdio_res_if.source          res,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CFG_AW-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// Configuration
	logic [HALF_W-1:0] half_q;
	logic              cfg_sel;

	assign pready  = 1'b1;
	assign cfg_sel = (reg_idx_t'(paddr[CFG_AW-1:2]) == REG_HALF_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_W'(2);
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			half_q <= pwdata[HALF_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (cfg_sel) begin
			prdata = {{(32-HALF_W){1'b0}}, half_q};
		end
	end

	// Frame state
	phase_t                phase_q, phase_n;
	logic [CNT_W-1:0]      bcnt_q, bcnt_n;
	logic [FRAME_BITS-1:0] frame_q, frame_n;
	logic [FRAME_BITS-1:0] saved_q, saved_n;
	logic [15:0]           dshift_q, dshift_n;
	logic [HALF_W-1:0]     div_q, div_n;
	logic                  clk_lvl_q, clk_lvl_n;
	logic                  pend_q, pend_n;
	logic [15:0]           rdata_q, rdata_n;
	logic                  rvalid_n;

	logic                  out_valid_q;
	res_t                  out_q;
	res_t                  res_n;
	logic                  accept;

	assign req.ready = !out_valid_q || res.ready;
	assign accept    = req.valid && req.ready;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	logic [HALF_W-1:0] half_eff;
	logic [HALF_W-1:0] div_inc;
	logic [CNT_W-1:0]  bcnt_inc;
	logic              is_read;
	logic              cmd_req;
	cmd_t              cmd;

	assign cmd      = cmd_t'(req.data.command);
	assign half_eff = (half_q == '0) ? HALF_W'(1) : half_q;
	assign div_inc  = div_q + HALF_W'(1);
	assign bcnt_inc = bcnt_q + CNT_W'(1);
	assign is_read  = frame_q[READ_BIT];

	always_comb begin
		cmd_req = 1'b0;
		case (cmd)
			CMD_C22_READ, CMD_C22_WRITE, CMD_C45_READ, CMD_C45_WRITE: cmd_req = 1'b1;
			default: cmd_req = 1'b0;
		endcase
	end

	// Next state for one word.
	always_comb begin
		phase_n   = phase_q;
		bcnt_n    = bcnt_q;
		frame_n   = frame_q;
		saved_n   = saved_q;
		dshift_n  = dshift_q;
		div_n     = div_q;
		clk_lvl_n = clk_lvl_q;
		pend_n    = pend_q;
		rdata_n   = rdata_q;
		rvalid_n  = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (cmd_req) begin
				pend_n = 1'b0;
				case (cmd)
					CMD_C22_READ: begin
						frame_n = make_frame(STOP_C22_READ, req.data.port_address,
							req.data.dev_or_reg, 16'h0000);
					end
					CMD_C22_WRITE: begin
						frame_n = make_frame(STOP_C22_WRITE, req.data.port_address,
							req.data.dev_or_reg, req.data.write_value);
					end
					CMD_C45_READ: begin
						frame_n = make_frame(STOP_C45_ADDR, req.data.port_address,
							req.data.dev_or_reg, req.data.reg_address);
						saved_n = make_frame(STOP_C45_READ, req.data.port_address,
							req.data.dev_or_reg, 16'h0000);
						pend_n  = 1'b1;
					end
					default: begin
						frame_n = make_frame(STOP_C45_ADDR, req.data.port_address,
							req.data.dev_or_reg, req.data.reg_address);
						saved_n = make_frame(STOP_C45_WRITE, req.data.port_address,
							req.data.dev_or_reg, req.data.write_value);
						pend_n  = 1'b1;
					end
				endcase
				phase_n   = PH_PRE;
				bcnt_n    = '0;
				div_n     = '0;
				clk_lvl_n = 1'b0;
				dshift_n  = '0;
			end
		end else if (cmd == CMD_TICK) begin
			if (div_inc >= half_eff) begin
				div_n = '0;
				if (!clk_lvl_q) begin
					clk_lvl_n = 1'b1;
				end else begin
					// End of a bit period. Read data is sampled for frame bits 15..30.
					if (phase_q == PH_FRAME && is_read && bcnt_q >= CNT_W'(15)
						&& bcnt_q <= CNT_W'(30)) begin
						dshift_n = {dshift_q[14:0], req.data.mdio_in};
					end
					bcnt_n = bcnt_inc;
					case (phase_q)
						PH_PRE: begin
							if (bcnt_inc >= CNT_W'(PREAMBLE_BITS)) begin
								phase_n = PH_FRAME;
								bcnt_n  = '0;
							end
							clk_lvl_n = 1'b0;
						end
						PH_FRAME: begin
							if (bcnt_inc >= CNT_W'(FRAME_BITS)) begin
								phase_n = PH_TRAIL;
								bcnt_n  = '0;
							end
							clk_lvl_n = 1'b0;
						end
						default: begin
							if (is_read) begin
								rdata_n  = dshift_q;
								rvalid_n = 1'b1;
							end
							if (pend_q) begin
								pend_n    = 1'b0;
								frame_n   = saved_q;
								phase_n   = PH_PRE;
								bcnt_n    = '0;
								div_n     = '0;
								clk_lvl_n = 1'b0;
								dshift_n  = '0;
							end else begin
								phase_n   = PH_IDLE;
								bcnt_n    = '0;
								clk_lvl_n = 1'b1;
							end
						end
					endcase
				end
			end else begin
				div_n = div_inc;
			end
		end
	end

	// Line levels after the word is applied.
	always_comb begin
		res_n.mdc        = clk_lvl_n;
		res_n.busy_res   = (phase_n != PH_IDLE);
		res_n.read_data  = rdata_n;
		res_n.read_valid = rvalid_n;
		case (phase_n)
			PH_IDLE: begin
				res_n.mdio_out   = 1'b1;
				res_n.mdio_drive = 1'b0;
			end
			PH_PRE: begin
				res_n.mdio_out   = 1'b1;
				res_n.mdio_drive = 1'b1;
			end
			PH_FRAME: begin
				// A read frame releases the line from the turnaround on.
				if (frame_n[READ_BIT] && bcnt_n >= CNT_W'(14)) begin
					res_n.mdio_out   = 1'b1;
					res_n.mdio_drive = 1'b0;
				end else begin
					res_n.mdio_out   = frame_n[~bcnt_n[4:0]];
					res_n.mdio_drive = 1'b1;
				end
			end
			default: begin
				res_n.mdio_out   = 1'b1;
				res_n.mdio_drive = !frame_n[READ_BIT];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bcnt_q    <= '0;
			frame_q   <= '0;
			saved_q   <= '0;
			dshift_q  <= '0;
			div_q     <= '0;
			clk_lvl_q <= 1'b1;
			pend_q    <= 1'b0;
			rdata_q   <= '0;
		end else if (accept) begin
			phase_q   <= phase_n;
			bcnt_q    <= bcnt_n;
			frame_q   <= frame_n;
			saved_q   <= saved_n;
			dshift_q  <= dshift_n;
			div_q     <= div_n;
			clk_lvl_q <= clk_lvl_n;
			pend_q    <= pend_n;
			rdata_q   <= rdata_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res_n;
		end
	end

	// Checks
	a_idle_mdc_high: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> clk_lvl_q)
		else $error("MDC low while idle");

	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (phase_q != PH_IDLE))
		else $error("second frame pending while idle");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted word produced no result");

	a_released_high: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.mdio_drive) |-> out_q.mdio_out)
		else $error("released line not reported high");

	a_read_valid_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rvalid_n) |=> (rdata_q == out_q.read_data))
		else $error("read data not held after completion");

endmodule

// File: dv/tb_mdio_management_master_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MDIO management master testbench
// Drives request and tick words into the MDIO master, predicts the MDC/MDIO
// line word that follows every request word and compares it field by field.
// The MDC half period is reprogrammed between traffic phases over APB.
// ----------------------------------------------------------------------------
module tb_mdio_management_master_unit;
	import mdio_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int BITS_PER_FRAME = PREAMBLE_BITS + FRAME_BITS + 1;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	mdio_req_if req ();
	mdio_res_if res ();

	mdio_management_master_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	req_t req_words[$];
	res_t line_expect[$];
	res_t want_word;
	logic word_taken = 1'b0;
	int   mismatch_count = 0;
	int   cycle_count = 0;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	int   hold_req = 0;
	int   hold_seen = 0;
	int   hold_left = 0;

	// Line model state.
	phase_t      ln_phase;
	logic [5:0]  ln_bits;
	logic [31:0] ln_frame;
	logic [31:0] ln_second;
	logic [15:0] ln_rx;
	logic [15:0] ln_div;
	logic [15:0] ln_half;
	logic [15:0] ln_last;
	logic        ln_mdc;
	logic        ln_pending;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic void note_mismatch(string what, int unsigned expv, int unsigned gotv);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s: expected %h, got %h", what, expv, gotv);
	endfunction

	function automatic void check_field(string what, int unsigned expv, int unsigned gotv);
		if (expv !== gotv)
			note_mismatch(what, expv, gotv);
	endfunction

	function automatic void begin_frame();
		ln_phase = PH_PRE;
		ln_bits  = '0;
		ln_div   = '0;
		ln_mdc   = 1'b0;
		ln_rx    = '0;
	endfunction

	// End of one MDC period; returns 1 when a read frame has just finished.
	function automatic logic close_bit(logic mi);
		logic done;
		done = 1'b0;
		if (ln_phase == PH_FRAME && ln_frame[READ_BIT] && ln_bits >= 15 && ln_bits <= 30)
			ln_rx = {ln_rx[14:0], mi};
		ln_bits = ln_bits + 6'd1;
		case (ln_phase)
			PH_PRE: begin
				if (ln_bits >= PREAMBLE_BITS) begin
					ln_phase = PH_FRAME;
					ln_bits  = '0;
				end
				ln_mdc = 1'b0;
			end
			PH_FRAME: begin
				if (ln_bits >= FRAME_BITS) begin
					ln_phase = PH_TRAIL;
					ln_bits  = '0;
				end
				ln_mdc = 1'b0;
			end
			default: begin
				if (ln_frame[READ_BIT]) begin
					ln_last = ln_rx;
					done    = 1'b1;
				end
				if (ln_pending) begin
					ln_pending = 1'b0;
					ln_frame   = ln_second;
					begin_frame();
				end else begin
					ln_phase = PH_IDLE;
					ln_bits  = '0;
					ln_mdc   = 1'b1;
				end
			end
		endcase
		return done;
	endfunction

	function automatic res_t next_line(req_t w);
		res_t       r;
		logic [15:0] h;
		logic [4:0]  pos;
		logic        done;
		done = 1'b0;
		if (ln_phase == PH_IDLE) begin
			case (w.command)
				CMD_C22_READ: begin
					ln_frame   = {STOP_C22_READ, w.port_address, w.dev_or_reg, TA_WRITE, 16'h0000};
					ln_pending = 1'b0;
					begin_frame();
				end
				CMD_C22_WRITE: begin
					ln_frame   = {STOP_C22_WRITE, w.port_address, w.dev_or_reg, TA_WRITE,
						w.write_value};
					ln_pending = 1'b0;
					begin_frame();
				end
				CMD_C45_READ, CMD_C45_WRITE: begin
					// The address frame goes first; the data frame waits behind it.
					ln_frame = {STOP_C45_ADDR, w.port_address, w.dev_or_reg, TA_WRITE,
						w.reg_address};
					if (w.command == CMD_C45_READ)
						ln_second = {STOP_C45_READ, w.port_address, w.dev_or_reg, TA_WRITE, 16'h0000};
					else
						ln_second = {STOP_C45_WRITE, w.port_address, w.dev_or_reg, TA_WRITE,
							w.write_value};
					ln_pending = 1'b1;
					begin_frame();
				end
				default: ;
			endcase
		end else if (w.command == CMD_TICK) begin
			h = (ln_half == '0) ? 16'd1 : ln_half;
			ln_div = ln_div + 16'd1;
			if (ln_div >= h) begin
				ln_div = '0;
				if (!ln_mdc)
					ln_mdc = 1'b1;
				else
					done = close_bit(w.mdio_in);
			end
		end
		r.mdc        = ln_mdc;
		r.busy_res   = (ln_phase != PH_IDLE);
		r.read_data  = ln_last;
		r.read_valid = done;
		case (ln_phase)
			PH_IDLE: begin
				r.mdio_out   = 1'b1;
				r.mdio_drive = 1'b0;
			end
			PH_PRE: begin
				r.mdio_out   = 1'b1;
				r.mdio_drive = 1'b1;
			end
			PH_FRAME: begin
				pos = 5'd31 - ln_bits[4:0];
				if (ln_frame[READ_BIT] && ln_bits >= 14) begin
					r.mdio_out   = 1'b1;
					r.mdio_drive = 1'b0;
				end else begin
					r.mdio_out   = ln_frame[pos];
					r.mdio_drive = 1'b1;
				end
			end
			default: begin
				r.mdio_out   = 1'b1;
				r.mdio_drive = !ln_frame[READ_BIT];
			end
		endcase
		return r;
	endfunction

	// Driver: a new word is offered once the previous one has been taken.
	always @(negedge clk) begin
		if (arst_n && (!req.valid || word_taken)) begin
			if (req_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				req.data  <= req_words.pop_front();
				req.valid <= 1'b1;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Result side ready, with a long hold-off on request from the stimulus.
	always @(negedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end
		res.ready <= arst_n && (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
	end

	// Monitor: check taken results first, then predict for the word taken now.
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (line_expect.size() == 0) begin
				note_mismatch("result with nothing expected", 0, 32'(res.data));
			end else begin
				want_word = line_expect.pop_front();
				check_field("mdc", want_word.mdc, res.data.mdc);
				check_field("mdio_out", want_word.mdio_out, res.data.mdio_out);
				check_field("mdio_drive", want_word.mdio_drive, res.data.mdio_drive);
				check_field("busy_res", want_word.busy_res, res.data.busy_res);
				check_field("read_data", want_word.read_data, res.data.read_data);
				check_field("read_valid", want_word.read_valid, res.data.read_valid);
			end
		end
		if (arst_n && req.valid && req.ready)
			line_expect.push_back(next_line(req.data));
		word_taken <= arst_n && req.valid && req.ready;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic cfg_access(input logic wr, input logic [15:0] v, output logic [31:0] rd);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {REG_HALF_PERIOD, 2'b00};
		pwdata  <= {16'h0000, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_half(input logic [15:0] v);
		logic [31:0] rd;
		cfg_access(1'b1, v, rd);
		cfg_access(1'b0, 16'h0000, rd);
		check_field("half_period_ticks readback", v, rd[15:0]);
		ln_half = v;
	endtask

	task automatic add_word(input logic [2:0] cmd, input logic [4:0] pa, input logic [4:0] dr,
		input logic [15:0] ra, input logic [15:0] wv, input logic mi);
		req_t w;
		w.command      = cmd;
		w.port_address = pa;
		w.dev_or_reg   = dr;
		w.reg_address  = ra;
		w.write_value  = wv;
		w.mdio_in      = mi;
		req_words.push_back(w);
	endtask

	task automatic add_random_word(input logic [2:0] cmd);
		add_word(cmd, 5'($urandom_range(31)), 5'($urandom_range(31)),
			16'($urandom_range(65535)), 16'($urandom_range(65535)), 1'($urandom_range(1)));
	endtask

	// Tick words with random side fields; mi_sel 0 or 1 fixes the line, 2 randomizes it.
	// A few words are swapped for requests or unused codes that land mid-frame.
	task automatic add_ticks(input int n, input int noise_pct, input int mi_sel);
		repeat (n) begin
			if ($urandom_range(99) < noise_pct)
				add_random_word(3'($urandom_range(1, 7)));
			else
				add_word(CMD_TICK, 5'($urandom_range(31)), 5'($urandom_range(31)),
					16'($urandom_range(65535)), 16'($urandom_range(65535)),
					(mi_sel == 2) ? 1'($urandom_range(1)) : 1'(mi_sel));
		end
	endtask

	// Mostly whole transactions with random content, some cut short or noisy.
	task automatic mdio_traffic(input int budget, input int half);
		int made;
		int run;
		int hp;
		logic [2:0] cmd;
		hp   = (half == 0) ? 1 : half;
		made = 0;
		while (made < budget) begin
			if ($urandom_range(99) < 85) begin
				cmd = 3'($urandom_range(CMD_C22_READ, CMD_C45_WRITE));
				add_random_word(cmd);
				made++;
				run = ((cmd >= CMD_C45_READ) ? 2 : 1) * BITS_PER_FRAME * 2 * hp;
				if ($urandom_range(7) == 0)
					run = $urandom_range(1, run);
				else
					run = run + $urandom_range(0, 4);
				if (run > budget - made)
					run = (budget - made > 0) ? budget - made : 1;
				add_ticks(run, 3, 2);
				made += run;
			end else begin
				add_random_word(3'($urandom_range(7)));
				made++;
			end
		end
	endtask

	task automatic wait_drained();
		while (req_words.size() != 0 || req.valid || line_expect.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	int unsigned phase_half[6] = '{1, 0, 2, 65535, 3, 1};
	int          phase_items[6] = '{120, 80, 120, 40, 80, 120};

	initial begin
		logic [31:0] rd;
		logic [15:0] h;
		ln_phase   = PH_IDLE;
		ln_bits    = '0;
		ln_frame   = '0;
		ln_second  = '0;
		ln_rx      = '0;
		ln_div     = '0;
		ln_half    = 16'd2;
		ln_last    = '0;
		ln_mdc     = 1'b1;
		ln_pending = 1'b0;
		req.valid  = 1'b0;
		req.data   = '0;
		res.ready  = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		arst_n     = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		cfg_access(1'b0, 16'h0000, rd);
		check_field("half_period_ticks after reset", 16'd2, rd[15:0]);

		// Directed: idle ticks, unused codes, each request at field extremes.
		tx_idle_pct = 34;
		rx_idle_pct = 50;
		set_half(16'd1);
		add_word(CMD_TICK, 5'd31, 5'd31, 16'hFFFF, 16'hFFFF, 1'b1);
		add_word(3'd5, 5'd31, 5'd31, 16'hFFFF, 16'hFFFF, 1'b1);
		add_word(3'd6, 5'd0, 5'd0, 16'h0000, 16'h0000, 1'b0);
		add_word(3'd7, 5'd31, 5'd0, 16'hFFFF, 16'h0000, 1'b1);
		add_word(CMD_C22_READ, 5'd31, 5'd0, 16'h0000, 16'h0000, 1'b0);
		add_ticks(2 * BITS_PER_FRAME, 0, 1);
		add_word(CMD_C22_WRITE, 5'd0, 5'd31, 16'h0000, 16'hFFFF, 1'b0);
		add_ticks(40, 0, 2);
		// Requests and unused codes while busy leave the frame alone.
		add_word(CMD_C45_READ, 5'd31, 5'd31, 16'hFFFF, 16'hFFFF, 1'b1);
		add_word(3'd7, 5'd31, 5'd31, 16'hFFFF, 16'hFFFF, 1'b1);
		add_ticks(2 * BITS_PER_FRAME - 40, 0, 2);
		add_word(CMD_C45_READ, 5'd31, 5'd31, 16'hFFFF, 16'h0000, 1'b0);
		add_ticks(4 * BITS_PER_FRAME + 2, 0, 0);
		add_word(CMD_C45_WRITE, 5'd0, 5'd0, 16'h0000, 16'h0000, 1'b1);
		add_ticks(4 * BITS_PER_FRAME + 2, 0, 2);
		wait_drained();

		for (int p = 0; p < 6; p++) begin
			h = (p == 4) ? 16'($urandom_range(1, 5)) : 16'(phase_half[p]);
			if (p < 2) begin
				tx_idle_pct = 34;
				rx_idle_pct = 50;
			end else if (p < 4) begin
				tx_idle_pct = 50;
				rx_idle_pct = 34;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			set_half(h);
			// The slowest setting only sees the start of a frame; the next
			// phase finishes it at a short period.
			mdio_traffic(phase_items[p], int'(h));
			if (p == 0)
				hold_req++;
			wait_drained();
		end

		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: mdio_management_master_unit.f
hdl/mdio_pkg.sv
hdl/mdio_req_if.sv
hdl/mdio_res_if.sv
hdl/mdio_management_master_unit.sv
dv/tb_mdio_management_master_unit.sv
